/* src/abu_pkg.sv */
`timescale 1ns / 1ps

package abu_pkg;

	localparam int BYTE_W   = 8;
	localparam int SAMPLE_W = 32;
	localparam int COL_W    = 12;
	localparam int DEPTH_W  = 6;
	localparam int ALIGN_W  = 3;
	localparam int ROWS_W   = 13;
	localparam int PAD_W    = 6;
	localparam int BITCNT_W = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	localparam int DEF_MAX_ROW_SAMPLES = 4096;
	localparam int DEF_FIFO_DEPTH      = 2;

	localparam logic [DEPTH_W-1:0] MAX_DEPTH = 6'd32;
	localparam logic [ALIGN_W-1:0] MAX_ALIGN = 3'd4;

	localparam logic [DEPTH_W-1:0] RST_SAMPLE_BITS = 6'd8;
	localparam logic [ALIGN_W-1:0] RST_ALIGN_BYTES = 3'd0;
	localparam logic [ROWS_W-1:0]  RST_ROW_SAMPLES = 13'd1;

	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_BITS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_BYTES = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_SAMPLES = 2'd2;

	typedef struct packed {
		logic [DEPTH_W-1:0] sample_bits;
		logic [ALIGN_W-1:0] align_bytes;
		logic [ROWS_W-1:0]  row_samples;
	} abu_cfg_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample_value;
		logic [COL_W-1:0]    column_index;
		logic                row_last;
	} abu_result_t;

endpackage

/* src/abu_fifo.sv */
`timescale 1ns / 1ps

// Small queue; DEPTH must be a power of two, at least 2.
module abu_fifo import abu_pkg::*; #(
	parameter int WIDTH = BYTE_W,
	parameter int DEPTH = DEF_FIFO_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] data_in,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] data_out
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign data_out = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= data_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* src/abu_back.sv */
`timescale 1ns / 1ps

// Bit engine: each unstalled cycle skips padding and gathers bits of the
// current byte until either the byte runs out or one sample completes.
module abu_back import abu_pkg::*; #(
	parameter int MAX_ROW_SAMPLES = DEF_MAX_ROW_SAMPLES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  abu_cfg_t          cfg,
	input  logic              byte_valid,
	input  logic [BYTE_W-1:0] byte_data,
	output logic              byte_take,
	input  logic              res_full,
	output logic              res_push,
	output abu_result_t       res_data
);

	localparam int RW    = $clog2(MAX_ROW_SAMPLES + 1);
	localparam int CW    = (RW > ROWS_W) ? RW : ROWS_W;
	localparam int LW    = CW + 1;
	localparam int POS_W = (MAX_ROW_SAMPLES > 1) ? $clog2(MAX_ROW_SAMPLES) : 1;

	logic [BYTE_W-1:0]   byte_q;
	logic [BITCNT_W-1:0] left_q;
	logic                armed_q;
	logic [PAD_W-1:0]    pad_q;
	logic [SAMPLE_W-1:0] acc_q;
	logic [DEPTH_W-1:0]  nacc_q;
	logic [POS_W-1:0]    pos_q;

	logic [DEPTH_W-1:0]  eff_depth;
	logic [ALIGN_W-1:0]  eff_align;
	logic [CW-1:0]       row_ext;
	logic [CW-1:0]       eff_row;
	logic                use_new;
	logic                active;
	logic [BITCNT_W-1:0] avail;
	logic [BITCNT_W-1:0] avail2;
	logic [BYTE_W-1:0]   cur;
	logic [PAD_W-1:0]    span;
	logic [PAD_W-1:0]    arm_pad;
	logic [PAD_W-1:0]    pad_cur;
	logic [PAD_W-1:0]    pad_next;
	logic                drop;
	logic [BITCNT_W-1:0] r;
	logic [DEPTH_W-1:0]  need;
	logic [BITCNT_W-1:0] take;
	logic [BITCNT_W-1:0] shamt;
	logic [BYTE_W:0]     mask;
	logic [BYTE_W-1:0]   chunk;
	logic [SAMPLE_W-1:0] acc_new;
	logic [DEPTH_W-1:0]  nacc_new;
	logic                fire;
	logic                last;
	logic [LW-1:0]       pos_inc;
	logic [BITCNT_W-1:0] left_next;
	logic [POS_W+COL_W-1:0] col_wide;

	always_comb begin
		if (cfg.sample_bits == '0) begin
			eff_depth = DEPTH_W'(1);
		end else if (cfg.sample_bits > MAX_DEPTH) begin
			eff_depth = MAX_DEPTH;
		end else begin
			eff_depth = cfg.sample_bits;
		end
		eff_align = (cfg.align_bytes > MAX_ALIGN) ? MAX_ALIGN : cfg.align_bytes;

		row_ext = CW'(cfg.row_samples);
		if (row_ext == '0) begin
			eff_row = CW'(1);
		end else if (row_ext > CW'(MAX_ROW_SAMPLES)) begin
			eff_row = CW'(MAX_ROW_SAMPLES);
		end else begin
			eff_row = row_ext;
		end

		use_new = (left_q == '0);
		cur     = use_new ? byte_data : byte_q;
		if (use_new) begin
			avail = byte_valid ? BITCNT_W'(BYTE_W) : '0;
		end else begin
			avail = left_q;
		end
		active    = (avail != '0) && !res_full;
		byte_take = active && use_new;

		// alignment: span of align_bytes bytes, pad = span - depth clamped at zero
		span    = {eff_align, 3'b000};
		arm_pad = (span > eff_depth) ? (span - eff_depth) : '0;
		pad_cur = armed_q ? pad_q : arm_pad;
		// arming part way through a byte throws the rest of it away
		drop    = !armed_q && (eff_align != '0) && (avail != BITCNT_W'(BYTE_W));
		avail2  = drop ? '0 : avail;

		if (pad_cur >= PAD_W'(avail2)) begin
			pad_next = pad_cur - PAD_W'(avail2);
			r        = '0;
		end else begin
			pad_next = '0;
			r        = avail2 - pad_cur[BITCNT_W-1:0];
		end

		need = (nacc_q >= eff_depth) ? DEPTH_W'(1) : (eff_depth - nacc_q);
		take = (need > DEPTH_W'(r)) ? r : need[BITCNT_W-1:0];
		fire = (r != '0) && (DEPTH_W'(take) == need);

		shamt    = r - take;
		mask     = (BYTE_W+1)'(({{BYTE_W{1'b0}}, 1'b1} << take) - 1'b1);
		chunk    = (cur >> shamt) & mask[BYTE_W-1:0];
		acc_new  = (acc_q << take) | SAMPLE_W'(chunk);
		nacc_new = nacc_q + DEPTH_W'(take);

		pos_inc   = LW'(pos_q) + LW'(1);
		last      = (pos_inc >= LW'(eff_row));
		left_next = (fire && last) ? '0 : (r - take);

		col_wide = (POS_W+COL_W)'(pos_q);
		res_push = active && fire;
		res_data.sample_value = acc_new;
		res_data.column_index = col_wide[COL_W-1:0];
		res_data.row_last     = last;
	end

	always_ff @(posedge clk) begin
		if (byte_take) begin
			byte_q <= byte_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q  <= '0;
			armed_q <= 1'b0;
			pad_q   <= '0;
			acc_q   <= '0;
			nacc_q  <= '0;
			pos_q   <= '0;
		end else if (active) begin
			left_q  <= left_next;
			armed_q <= !fire;
			pad_q   <= pad_next;
			if (fire) begin
				acc_q  <= '0;
				nacc_q <= '0;
				pos_q  <= last ? '0 : pos_inc[POS_W-1:0];
			end else begin
				acc_q  <= acc_new;
				nacc_q <= nacc_new;
			end
		end
	end

endmodule

/* src/aligned_bit_sample_unpacker.sv */
`timescale 1ns / 1ps

// Channel   Handshake              Beat
// input     push / full            data_byte
// result    empty / pop            sample_value, column_index, row_last
// config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// The bit engine finishes at most one sample per cycle and stops there, so a
// byte that ends several samples is held while each completes in turn. Bits
// left after its last sample are carried on, or thrown away when the next
// aligned sample starts part way into the byte, or when a row ends there.
// Queues of FIFO_DEPTH entries (two by default) sit in front of and behind
// the engine. Reset clears all state at once; no start-up sweep. A full
// result queue stalls the engine; the input queue then fills.
module aligned_bit_sample_unpacker import abu_pkg::*; #(
	parameter int MAX_ROW_SAMPLES = DEF_MAX_ROW_SAMPLES,
	parameter int FIFO_DEPTH      = DEF_FIFO_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [BYTE_W-1:0]     data_byte,
	output logic                  empty,
	input  logic                  pop,
	output logic [SAMPLE_W-1:0]   sample_value,
	output logic [COL_W-1:0]      column_index,
	output logic                  row_last,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	abu_cfg_t          cfg_q;
	logic              in_empty;
	logic [BYTE_W-1:0] in_byte;
	logic              byte_take;
	logic              res_full;
	logic              res_push;
	abu_result_t       res_in;
	abu_result_t       res_out;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sample_bits <= RST_SAMPLE_BITS;
			cfg_q.align_bytes <= RST_ALIGN_BYTES;
			cfg_q.row_samples <= RST_ROW_SAMPLES;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SAMPLE_BITS: cfg_q.sample_bits <= cfg_data[DEPTH_W-1:0];
				CFG_ALIGN_BYTES: cfg_q.align_bytes <= cfg_data[ALIGN_W-1:0];
				CFG_ROW_SAMPLES: cfg_q.row_samples <= cfg_data[ROWS_W-1:0];
				default: ;
			endcase
		end
	end

	abu_fifo #(
		.WIDTH(BYTE_W),
		.DEPTH(FIFO_DEPTH)
	) u_in_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.data_in (data_byte),
		.pop     (byte_take),
		.empty   (in_empty),
		.data_out(in_byte)
	);

	abu_back #(
		.MAX_ROW_SAMPLES(MAX_ROW_SAMPLES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.byte_valid(!in_empty),
		.byte_data (in_byte),
		.byte_take (byte_take),
		.res_full  (res_full),
		.res_push  (res_push),
		.res_data  (res_in)
	);

	abu_fifo #(
		.WIDTH($bits(abu_result_t)),
		.DEPTH(FIFO_DEPTH)
	) u_out_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (res_push),
		.full    (res_full),
		.data_in (res_in),
		.pop     (pop),
		.empty   (empty),
		.data_out(res_out)
	);

	assign sample_value = res_out.sample_value;
	assign column_index = res_out.column_index;
	assign row_last     = res_out.row_last;

endmodule
